/* src/fnvs_pkg.sv */
// ---------------------------------------------------------------------------
// fnvs_pkg - shared types and constants of the face normal / vertex split unit
// Beat layouts, status codes, register indexes and datapath widths.
// ---------------------------------------------------------------------------
`default_nettype none

package fnvs_pkg;

    // Sizing of the vertex map and the corner buffer
    localparam int MaxVertices = 65536;
    localparam int MaxCorners  = 16;
    localparam int MinCorners  = 3;
    localparam int MapAw       = $clog2(MaxVertices);
    localparam int CntW        = $clog2(MaxCorners + 1);
    localparam int SlotW       = $clog2(MaxCorners);
    localparam int IdxLimit    = (MaxVertices < 65536) ? MaxVertices : 65536;

    // Field and datapath widths
    localparam int IdxW   = 16;
    localparam int PosW   = 24;
    localparam int EdgeW  = PosW + 1;
    localparam int CrossW = 51;
    localparam int MagW   = 50;
    localparam int NormW  = 31;
    localparam int MulW   = 32;
    localparam int SumW   = 64;
    localparam int LenW   = 32;
    localparam int NumW   = NormW + 16;
    localparam int NrmW   = 16;
    localparam int CfgW   = 17;
    localparam logic [NrmW-1:0] NrmMax = 16'h7FFF;

    // Configuration register indexes
    localparam logic CfgVertexCount = 1'b0;
    localparam logic CfgFlipWinding = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [PosW-1:0] x;
        logic signed [PosW-1:0] y;
        logic signed [PosW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [NrmW-1:0] x;
        logic signed [NrmW-1:0] y;
        logic signed [NrmW-1:0] z;
    } t_normal;

    typedef struct packed {
        logic [IdxW-1:0]        vertex_index;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
        logic                   last_corner;
    } t_in;

    typedef struct packed {
        logic [IdxW-1:0]        new_index;
        logic [IdxW-1:0]        source_index;
        logic signed [NrmW-1:0] normal_x;
        logic signed [NrmW-1:0] normal_y;
        logic signed [NrmW-1:0] normal_z;
        logic                   normal_defined;
        t_status                status;
        logic                   last_of_face;
    } t_out;

endpackage

`default_nettype wire

/* src/fnvs_ram.sv */
// ---------------------------------------------------------------------------
// fnvs_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fnvs_ram #(
    parameter int Width = 1,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]              o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/fnvs_normal.sv */
// ---------------------------------------------------------------------------
// fnvs_normal - sequenced unit normal of one face
// Cross product through one shared multiplier, block normalize, bit-pair
// square root and restoring division, one step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fnvs_normal (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire fnvs_pkg::t_vec  i_p1,
    input  wire fnvs_pkg::t_vec  i_p2,
    input  wire fnvs_pkg::t_vec  i_p3,
    output logic                 o_done,
    output fnvs_pkg::t_normal    o_normal
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MAG, S_SHIFT, S_SQR, S_ROOT,
        S_DINIT, S_DLOAD, S_DIV, S_DSTORE, S_DONE
    } t_state;

    t_state r_state;
    logic [5:0] r_step;
    logic [1:0] r_i;
    logic       r_done;

    logic signed [fnvs_pkg::EdgeW-1:0]  r_a [3];
    logic signed [fnvs_pkg::EdgeW-1:0]  r_b [3];
    logic signed [fnvs_pkg::CrossW-1:0] r_c [3];
    logic [fnvs_pkg::MagW-1:0]          r_m [3];
    logic signed [2*fnvs_pkg::MulW-1:0] r_prod;
    logic [fnvs_pkg::SumW-1:0]          r_x;
    logic [fnvs_pkg::SumW-1:0]          r_r;
    logic [fnvs_pkg::SumW-1:0]          r_bit;
    logic [fnvs_pkg::LenW-1:0]          r_len;
    logic [fnvs_pkg::NumW-1:0]          r_num;
    logic [fnvs_pkg::LenW-1:0]          r_rem;
    logic signed [fnvs_pkg::NrmW-1:0]   r_n [3];

    logic signed [fnvs_pkg::PosW-1:0] w_p1 [3];
    logic signed [fnvs_pkg::PosW-1:0] w_p2 [3];
    logic signed [fnvs_pkg::PosW-1:0] w_p3 [3];

    logic signed [fnvs_pkg::MulW-1:0]   w_op_a;
    logic signed [fnvs_pkg::MulW-1:0]   w_op_b;
    logic signed [2*fnvs_pkg::MulW-1:0] w_prod;
    logic signed [fnvs_pkg::CrossW-1:0] w_prod_c;
    logic [1:0]                         w_j;
    logic                               w_big;
    logic [fnvs_pkg::SumW-1:0]          w_t;
    logic [fnvs_pkg::LenW:0]            w_rem_sh;
    logic                               w_ge;
    logic [fnvs_pkg::NrmW-1:0]          w_q;

    assign w_p1[0] = i_p1.x;
    assign w_p1[1] = i_p1.y;
    assign w_p1[2] = i_p1.z;
    assign w_p2[0] = i_p2.x;
    assign w_p2[1] = i_p2.y;
    assign w_p2[2] = i_p2.z;
    assign w_p3[0] = i_p3.x;
    assign w_p3[1] = i_p3.y;
    assign w_p3[2] = i_p3.z;

    // Select multiplier operands: cross terms, then squares
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                6'd0: begin w_op_a = 32'(r_a[1]); w_op_b = 32'(r_b[2]); end
                6'd1: begin w_op_a = 32'(r_a[2]); w_op_b = 32'(r_b[1]); end
                6'd2: begin w_op_a = 32'(r_a[2]); w_op_b = 32'(r_b[0]); end
                6'd3: begin w_op_a = 32'(r_a[0]); w_op_b = 32'(r_b[2]); end
                6'd4: begin w_op_a = 32'(r_a[0]); w_op_b = 32'(r_b[1]); end
                6'd5: begin w_op_a = 32'(r_a[1]); w_op_b = 32'(r_b[0]); end
                default: begin w_op_a = '0; w_op_b = '0; end
            endcase
        end else if (r_state == S_SQR) begin
            case (r_step)
                6'd0: w_op_a = $signed({1'b0, r_m[0][fnvs_pkg::NormW-1:0]});
                6'd1: w_op_a = $signed({1'b0, r_m[1][fnvs_pkg::NormW-1:0]});
                6'd2: w_op_a = $signed({1'b0, r_m[2][fnvs_pkg::NormW-1:0]});
                default: w_op_a = '0;
            endcase
            w_op_b = w_op_a;
        end
    end

    assign w_prod   = w_op_a * w_op_b;
    assign w_prod_c = r_prod[fnvs_pkg::CrossW-1:0];
    assign w_j      = 2'((r_step - 6'd1) >> 1);

    // Any magnitude at or above 2^31 forces one more shift
    assign w_big = (|r_m[0][fnvs_pkg::MagW-1:fnvs_pkg::NormW])
                 | (|r_m[1][fnvs_pkg::MagW-1:fnvs_pkg::NormW])
                 | (|r_m[2][fnvs_pkg::MagW-1:fnvs_pkg::NormW]);

    // Root step and division step
    assign w_t      = r_r + r_bit;
    assign w_rem_sh = {r_rem, r_num[fnvs_pkg::NumW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_len});
    assign w_q      = (r_num > fnvs_pkg::NumW'(fnvs_pkg::NrmMax))
                    ? fnvs_pkg::NrmMax : r_num[fnvs_pkg::NrmW-1:0];

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_i     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_a[i] <= fnvs_pkg::EdgeW'(w_p2[i])
                                    - fnvs_pkg::EdgeW'(w_p1[i]);
                            r_b[i] <= fnvs_pkg::EdgeW'(w_p3[i])
                                    - fnvs_pkg::EdgeW'(w_p1[i]);
                        end
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step < 6'd6) begin
                        r_prod <= w_prod;
                    end
                    if (r_step != 6'd0) begin
                        if (r_step[0]) begin
                            r_c[w_j] <= w_prod_c;
                        end else begin
                            r_c[w_j] <= r_c[w_j] - w_prod_c;
                        end
                    end
                    if (r_step == 6'd6) begin
                        r_state <= S_MAG;
                    end
                    r_step <= r_step + 6'd1;
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_c[i][fnvs_pkg::CrossW-1]
                                ? fnvs_pkg::MagW'(-r_c[i])
                                : fnvs_pkg::MagW'(r_c[i]);
                    end
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (w_big) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else begin
                        r_step  <= '0;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (r_step < 6'd3) begin
                        r_prod <= w_prod;
                    end
                    if (r_step == 6'd1) begin
                        r_x <= $unsigned(r_prod);
                    end else if (r_step != 6'd0) begin
                        r_x <= r_x + $unsigned(r_prod);
                    end
                    if (r_step == 6'd3) begin
                        r_r     <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_step  <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_step <= r_step + 6'd1;
                    end
                end
                S_ROOT: begin
                    if (r_x >= w_t) begin
                        r_x <= r_x - w_t;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd31) begin
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_len <= r_r[fnvs_pkg::LenW-1:0];
                    r_i   <= '0;
                    if (r_r == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_n[i] <= '0;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    r_num <= {1'b0, r_m[r_i][fnvs_pkg::NormW-1:0], 15'd0}
                           + fnvs_pkg::NumW'(r_len >> 1);
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_ge ? fnvs_pkg::LenW'(w_rem_sh - {1'b0, r_len})
                                   : w_rem_sh[fnvs_pkg::LenW-1:0];
                    r_num  <= {r_num[fnvs_pkg::NumW-2:0], w_ge};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(fnvs_pkg::NumW - 1)) begin
                        r_state <= S_DSTORE;
                    end
                end
                S_DSTORE: begin
                    r_n[r_i] <= r_c[r_i][fnvs_pkg::CrossW-1] ? -$signed(w_q)
                                                             : $signed(w_q);
                    if (r_i == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_DLOAD;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_normal.x = r_n[0];
    assign o_normal.y = r_n[1];
    assign o_normal.z = r_n[2];

endmodule

`default_nettype wire

/* src/face_normal_vertex_split_unit.sv */
// ---------------------------------------------------------------------------
// face_normal_vertex_split_unit - flat face normals with vertex splitting
// Buffers face corners, computes the unit face normal at the last corner and
// emits one beat per corner with a split vertex index.
// ---------------------------------------------------------------------------
// A corner that does not end a face is taken without leaving the idle state.
// The last corner of a face of three or more corners starts the normal unit
// (six products and three squares on one multiplier, up to 19 normalize
// shifts, 32 root steps and three 47-step divisions); shorter faces skip it.
// Each corner beat then passes a read and an update of the referenced-vertex
// RAM and waits in the update on any output stall. After reset and after
// every vertex_count write the referenced map is cleared by a pass over all
// 65536 entries, during which no corner is taken; configuration writes are
// taken at any time and are meant to be issued while the block is idle.
`default_nettype none

module face_normal_vertex_split_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire fnvs_pkg::t_in                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output fnvs_pkg::t_out                     o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [fnvs_pkg::CfgW-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_NORM, S_READ, S_CHECK
    } t_state;

    t_state r_state;
    logic [fnvs_pkg::MapAw-1:0] r_clr;
    logic [fnvs_pkg::CfgW-1:0]  r_next;
    logic                       r_flip;
    logic [fnvs_pkg::CntW-1:0]  r_cnt;
    logic [fnvs_pkg::SlotW-1:0] r_k;
    logic                       r_long;
    logic                       r_nstart;
    logic                       r_defined;
    fnvs_pkg::t_normal          r_nrm;
    fnvs_pkg::t_vec             r_first;
    fnvs_pkg::t_vec             r_second;
    fnvs_pkg::t_vec             r_latest;
    logic [fnvs_pkg::IdxW-1:0]  r_buf [fnvs_pkg::MaxCorners];
    logic                       r_out_valid;
    fnvs_pkg::t_out             r_out;

    fnvs_pkg::t_out             n_out;
    logic                       n_adv;
    fnvs_pkg::t_vec             w_pos;
    fnvs_pkg::t_vec             w_p2;
    fnvs_pkg::t_vec             w_p3;
    fnvs_pkg::t_normal          w_nrm;
    logic                       w_ndone;
    logic                       w_in_beat;
    logic                       w_out_free;
    logic                       w_emit;
    logic                       w_last;
    logic                       w_cfg_count;
    logic                       w_cfg_flip;
    logic [fnvs_pkg::CntW-1:0]  w_cnt_next;
    logic [fnvs_pkg::SlotW-1:0] w_slot;
    logic [fnvs_pkg::IdxW-1:0]  w_src;
    logic                       w_tracked;
    logic                       w_map_we;
    logic [fnvs_pkg::MapAw-1:0] w_map_waddr;
    logic                       w_map_wdata;
    logic [fnvs_pkg::MapAw-1:0] w_map_raddr;
    logic                       w_map_rdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_cfg_count = i_cfg_valid && (i_cfg_index == fnvs_pkg::CfgVertexCount);
    assign w_cfg_flip  = i_cfg_valid && (i_cfg_index == fnvs_pkg::CfgFlipWinding);
    assign w_in_beat   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = (r_state == S_CHECK) && w_out_free && !w_cfg_count;

    assign w_pos.x = i_in_data.pos_x;
    assign w_pos.y = i_in_data.pos_y;
    assign w_pos.z = i_in_data.pos_z;

    // Corner slot: the last slot takes every corner past the buffer depth
    assign w_cnt_next = (r_cnt < fnvs_pkg::CntW'(fnvs_pkg::MaxCorners))
                      ? r_cnt + 1'b1 : r_cnt;
    assign w_slot     = (r_cnt < fnvs_pkg::CntW'(fnvs_pkg::MaxCorners))
                      ? r_cnt[fnvs_pkg::SlotW-1:0]
                      : fnvs_pkg::SlotW'(fnvs_pkg::MaxCorners - 1);

    // Swap second and last corner for flipped winding
    assign w_p2 = r_flip ? r_latest : r_second;
    assign w_p3 = r_flip ? r_second : r_latest;

    fnvs_normal u_normal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_nstart),
        .i_p1     (r_first),
        .i_p2     (w_p2),
        .i_p3     (w_p3),
        .o_done   (w_ndone),
        .o_normal (w_nrm)
    );

    // Referenced-vertex map
    assign w_src       = r_buf[r_k];
    assign w_tracked   = (32'(w_src) < fnvs_pkg::MaxVertices);
    assign w_map_raddr = fnvs_pkg::MapAw'(w_src);
    assign w_last      = (fnvs_pkg::CntW'(r_k) + 1'b1 == r_cnt);

    always_comb begin
        w_map_we    = 1'b0;
        w_map_waddr = w_map_raddr;
        w_map_wdata = 1'b1;
        if (r_state == S_CLEAR) begin
            w_map_we    = 1'b1;
            w_map_waddr = r_clr;
            w_map_wdata = 1'b0;
        end else if (w_emit && w_tracked && !w_map_rdata) begin
            w_map_we = 1'b1;
        end
    end

    fnvs_ram #(
        .Width (1),
        .Depth (fnvs_pkg::MaxVertices)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    // Build the result beat of the current corner
    always_comb begin
        n_adv                = 1'b0;
        n_out.new_index      = w_src;
        n_out.source_index   = w_src;
        n_out.normal_x       = r_nrm.x;
        n_out.normal_y       = r_nrm.y;
        n_out.normal_z       = r_nrm.z;
        n_out.normal_defined = r_defined;
        n_out.status         = r_long ? fnvs_pkg::ST_LONG : fnvs_pkg::ST_OK;
        n_out.last_of_face   = w_last;
        if (w_tracked && w_map_rdata) begin
            if (r_next >= fnvs_pkg::CfgW'(fnvs_pkg::IdxLimit)) begin
                n_out.new_index = fnvs_pkg::IdxW'(fnvs_pkg::IdxLimit - 1);
                n_out.status    = fnvs_pkg::ST_FULL;
            end else begin
                n_out.new_index = r_next[fnvs_pkg::IdxW-1:0];
                n_adv           = 1'b1;
            end
        end
    end

    // Control sequencer, corner buffer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next      <= '0;
            r_flip      <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_long      <= 1'b0;
            r_nstart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_nstart <= 1'b0;
            // Drop the output beat once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            // Load vertex_count and restart the map clear
            if (w_cfg_count) begin
                r_next  <= i_cfg_data;
                r_clr   <= '0;
                r_state <= S_CLEAR;
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + 1'b1;
                        if (r_clr == fnvs_pkg::MapAw'(fnvs_pkg::MaxVertices - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_in_beat) begin
                            if (r_cnt == '0) begin
                                r_first <= w_pos;
                            end
                            if (r_cnt == fnvs_pkg::CntW'(1)) begin
                                r_second <= w_pos;
                            end
                            r_latest      <= w_pos;
                            r_buf[w_slot] <= i_in_data.vertex_index;
                            r_cnt         <= w_cnt_next;
                            if (r_cnt == w_cnt_next) begin
                                r_long <= 1'b1;
                            end
                            if (i_in_data.last_corner) begin
                                r_k <= '0;
                                if (w_cnt_next >= fnvs_pkg::CntW'(fnvs_pkg::MinCorners)) begin
                                    r_nstart <= 1'b1;
                                    r_state  <= S_NORM;
                                end else begin
                                    r_nrm     <= '0;
                                    r_defined <= 1'b0;
                                    r_state   <= S_READ;
                                end
                            end
                        end
                    end
                    S_NORM: begin
                        if (w_ndone) begin
                            r_nrm     <= w_nrm;
                            r_defined <= 1'b1;
                            r_state   <= S_READ;
                        end
                    end
                    S_READ: begin
                        r_state <= S_CHECK;
                    end
                    S_CHECK: begin
                        if (w_emit) begin
                            r_out       <= n_out;
                            r_out_valid <= 1'b1;
                            if (n_adv) begin
                                r_next <= r_next + 1'b1;
                            end
                            if (w_last) begin
                                r_cnt   <= '0;
                                r_long  <= 1'b0;
                                r_state <= S_IDLE;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_READ;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
            // Winding register write
            if (w_cfg_flip) begin
                r_flip <= i_cfg_data[0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The normal unit finishes only while the sequencer waits for it
    a_done_in_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ndone |-> (r_state == S_NORM))
        else $error("normal unit finished outside the wait state");

    // A full table always saturates the index
    a_full_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_out_data.status == fnvs_pkg::ST_FULL))
        |-> (o_out_data.new_index == fnvs_pkg::IdxW'(fnvs_pkg::IdxLimit - 1)))
        else $error("full-table beat without saturated index");

    // Short faces carry a zero normal
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.normal_defined)
        |-> (o_out_data.normal_x == '0 && o_out_data.normal_y == '0
             && o_out_data.normal_z == '0))
        else $error("undefined normal is not zero");

endmodule

`default_nettype wire
